// ===== sv/fast_inverse_square_root_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, removed in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef FAST_INVERSE_SQUARE_ROOT_UNIT_MACROS_SVH
`define FAST_INVERSE_SQUARE_ROOT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FISR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FISR_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FISR_ASSERT(lbl, prop, msg)
`define FISR_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== sv/fisr_pkg.sv =====
// ---------------------------------------------------------------------------
// fisr_pkg
// Constants and shared float helpers for the reciprocal square root unit.
// ---------------------------------------------------------------------------
package fisr_pkg;

    localparam int unsigned FISR_STAGES = 10;
    localparam int unsigned FISR_GUESS_DEPTH = 8;

    localparam logic [31:0] FISR_MAGIC        = 32'h5F3759DF;
    localparam logic [31:0] FISR_HALF         = 32'h3F000000;
    localparam logic [31:0] FISR_THREE_HALVES = 32'h3FC00000;
    localparam logic [31:0] FISR_QNAN         = 32'hFFC00000;
    localparam logic [31:0] FISR_QBIT         = 32'h00400000;
    localparam logic [7:0]  FISR_EXP_MAX      = 8'hFF;

    function automatic logic [5:0] fisr_lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found && v[i])
            begin
                n = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // pn is normalized (bit 47 set); e is the biased exponent of that value
    function automatic logic [31:0] fisr_round_pack(input logic sgn,
                                                    input logic signed [10:0] e,
                                                    input logic [47:0] pn);
        logic [95:0]        sh;
        logic [5:0]         amt;
        logic [47:0]        m;
        logic               sticky;
        logic [7:0]         ef;
        logic [30:0]        body;
        logic               rnd;
        logic signed [10:0] d;
        d = 11'sd1 - e;
        if (e >= 11'sd255)
        begin
            return {sgn, FISR_EXP_MAX, 23'b0};
        end
        if (e < 11'sd1)
        begin
            amt = (d > 11'sd63) ? 6'd63 : d[5:0];
            sh = {pn, 48'b0} >> amt;
            m = sh[95:48];
            sticky = |sh[47:0];
            ef = 8'd0;
        end
        else
        begin
            m = pn;
            sticky = 1'b0;
            ef = e[7:0];
        end
        sticky = sticky | (|m[22:0]);
        body = {ef, m[46:24]};
        rnd = m[23] & (sticky | m[24]);
        return {sgn, body + {30'b0, rnd}};
    endfunction

endpackage

// ===== sv/fisr_if.sv =====
// ---------------------------------------------------------------------------
// fisr_if
// Valid/ready word channels for operand and result.
// ---------------------------------------------------------------------------
interface fisr_x_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_bits;
    modport source (output valid, output x_bits, input ready);
    modport sink (input valid, input x_bits, output ready);
endinterface

interface fisr_rsqrt_if;
    logic        valid;
    logic        ready;
    logic [31:0] rsqrt_bits;
    modport source (output valid, output rsqrt_bits, input ready);
    modport sink (input valid, input rsqrt_bits, output ready);
endinterface

// ===== sv/fisr_fmul.sv =====
// ---------------------------------------------------------------------------
// fisr_fmul
// Two-stage single-precision multiplier, round to nearest even.
// ---------------------------------------------------------------------------
module fisr_fmul
    import fisr_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    logic [47:0] p_reg, p_next;
    logic [8:0]  es_reg, es_next;
    logic        sgn_reg, sgn_next;
    logic        spec_reg, spec_next;
    logic [31:0] sval_reg, sval_next;
    logic [31:0] y_reg, y_next;

    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

    always_comb
    begin
        ea = a[30:23];
        eb = b[30:23];
        ma = {|ea, a[22:0]};
        mb = {|eb, b[22:0]};
        nan_a = (ea == FISR_EXP_MAX) && (a[22:0] != 23'd0);
        nan_b = (eb == FISR_EXP_MAX) && (b[22:0] != 23'd0);
        inf_a = (ea == FISR_EXP_MAX) && (a[22:0] == 23'd0);
        inf_b = (eb == FISR_EXP_MAX) && (b[22:0] == 23'd0);
        zero_a = (a[30:0] == 31'd0);
        zero_b = (b[30:0] == 31'd0);
        sgn_next = a[31] ^ b[31];
        p_next = ma * mb;
        es_next = {1'b0, (ea == 8'd0) ? 8'd1 : ea} + {1'b0, (eb == 8'd0) ? 8'd1 : eb};
        spec_next = 1'b1;
        if (nan_a)
        begin
            sval_next = a | FISR_QBIT;
        end
        else if (nan_b)
        begin
            sval_next = b | FISR_QBIT;
        end
        else if ((inf_a && zero_b) || (zero_a && inf_b))
        begin
            sval_next = FISR_QNAN;
        end
        else if (inf_a || inf_b)
        begin
            sval_next = {sgn_next, FISR_EXP_MAX, 23'b0};
        end
        else
        begin
            spec_next = 1'b0;
            sval_next = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
            es_reg <= es_next;
            sgn_reg <= sgn_next;
            spec_reg <= spec_next;
            sval_reg <= sval_next;
        end
    end

    logic [5:0]         lz;
    logic [47:0]        pn;
    logic signed [10:0] e;

    always_comb
    begin
        lz = fisr_lzc48(p_reg);
        pn = p_reg << lz;
        e = $signed({2'b0, es_reg}) - 11'sd126 - $signed({5'b0, lz});
        if (spec_reg)
        begin
            y_next = sval_reg;
        end
        else if (p_reg == 48'd0)
        begin
            y_next = {sgn_reg, 31'b0};
        end
        else
        begin
            y_next = fisr_round_pack(sgn_reg, e, pn);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== sv/fisr_fsub.sv =====
// ---------------------------------------------------------------------------
// fisr_fsub
// Two-stage single-precision subtractor y = a - b, round to nearest even.
// ---------------------------------------------------------------------------
module fisr_fsub
    import fisr_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    logic [27:0] sum_reg, sum_next;
    logic [7:0]  e_reg, e_next;
    logic        sgn_reg, sgn_next;
    logic        zsgn_reg, zsgn_next;
    logic        spec_reg, spec_next;
    logic [31:0] sval_reg, sval_next;
    logic [31:0] y_reg, y_next;

    logic [31:0] bn, big, sml;
    logic [7:0]  ebig, esml, d;
    logic [4:0]  amt;
    logic [26:0] mbig3, msml3, al;
    logic [53:0] sh;
    logic        sub;
    logic        nan_a, nan_b, inf_a, inf_b;

    always_comb
    begin
        bn = b ^ {1'b1, 31'b0};
        nan_a = (a[30:23] == FISR_EXP_MAX) && (a[22:0] != 23'd0);
        nan_b = (b[30:23] == FISR_EXP_MAX) && (b[22:0] != 23'd0);
        inf_a = (a[30:23] == FISR_EXP_MAX) && (a[22:0] == 23'd0);
        inf_b = (b[30:23] == FISR_EXP_MAX) && (b[22:0] == 23'd0);
        if (a[30:0] >= bn[30:0])
        begin
            big = a;
            sml = bn;
        end
        else
        begin
            big = bn;
            sml = a;
        end
        ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mbig3 = {|big[30:23], big[22:0], 3'b0};
        msml3 = {|sml[30:23], sml[22:0], 3'b0};
        d = ebig - esml;
        amt = (d > 8'd31) ? 5'd31 : d[4:0];
        sh = {msml3, 27'b0} >> amt;
        al = {sh[53:28], sh[27] | (|sh[26:0])};
        sub = a[31] ^ bn[31];
        sum_next = sub ? ({1'b0, mbig3} - {1'b0, al}) : ({1'b0, mbig3} + {1'b0, al});
        e_next = ebig;
        sgn_next = big[31];
        zsgn_next = sub ? 1'b0 : big[31];
        spec_next = 1'b1;
        if (nan_a)
        begin
            sval_next = a | FISR_QBIT;
        end
        else if (nan_b)
        begin
            sval_next = b | FISR_QBIT;
        end
        else if (inf_a && inf_b && sub)
        begin
            sval_next = FISR_QNAN;
        end
        else if (inf_a)
        begin
            sval_next = a;
        end
        else if (inf_b)
        begin
            sval_next = bn;
        end
        else
        begin
            spec_next = 1'b0;
            sval_next = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
            e_reg <= e_next;
            sgn_reg <= sgn_next;
            zsgn_reg <= zsgn_next;
            spec_reg <= spec_next;
            sval_reg <= sval_next;
        end
    end

    logic [47:0]        pw, pn;
    logic [5:0]         lz;
    logic signed [10:0] e;

    always_comb
    begin
        pw = {sum_reg, 20'b0};
        lz = fisr_lzc48(pw);
        pn = pw << lz;
        e = $signed({3'b0, e_reg}) + 11'sd1 - $signed({5'b0, lz});
        if (spec_reg)
        begin
            y_next = sval_reg;
        end
        else if (sum_reg == 28'd0)
        begin
            y_next = {zsgn_reg, 31'b0};
        end
        else
        begin
            y_next = fisr_round_pack(sgn_reg, e, pn);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== sv/fast_inverse_square_root_unit.sv =====
// ---------------------------------------------------------------------------
// fast_inverse_square_root_unit
// Approximate 1/sqrt(x) on single-precision words: magic-constant guess and
// one Newton step, every float operation rounded to nearest even.
// ---------------------------------------------------------------------------
// Takes one word per cycle unless the pipe holds, and returns the results in
// order. The path is five chained float operations (0.5*x, two products
// with the guess, the subtraction from 1.5 and the final product), each a
// two-stage unit. The whole pipe holds while the result word waits to be
// taken; x_in.ready follows rsqrt_out.ready when it does.
// Negative, zero, infinite and NaN operands get no special treatment.
`include "fast_inverse_square_root_unit_macros.svh"

module fast_inverse_square_root_unit
    import fisr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fisr_x_if.sink       x_in,
    fisr_rsqrt_if.source rsqrt_out
);

    logic                   en;
    logic [FISR_STAGES-1:0] vld_reg, vld_next;
    logic [31:0]            guess_reg [FISR_GUESS_DEPTH];
    logic [31:0]            guess_next;
    logic [31:0]            half_x, p1, p2, corr, res;

    assign en = !vld_reg[FISR_STAGES-1] || rsqrt_out.ready;
    assign x_in.ready = en;
    assign guess_next = FISR_MAGIC - {1'b0, x_in.x_bits[31:1]};
    assign vld_next = {vld_reg[FISR_STAGES-2:0], x_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            guess_reg[0] <= guess_next;
            for (int i = 1; i < FISR_GUESS_DEPTH; i++)
            begin
                guess_reg[i] <= guess_reg[i-1];
            end
        end
    end

    fisr_fmul u_half (.clk(clk), .en(en), .a(x_in.x_bits), .b(FISR_HALF), .y(half_x));
    fisr_fmul u_p1 (.clk(clk), .en(en), .a(half_x), .b(guess_reg[1]), .y(p1));
    fisr_fmul u_p2 (.clk(clk), .en(en), .a(p1), .b(guess_reg[3]), .y(p2));
    fisr_fsub u_corr (.clk(clk), .en(en), .a(FISR_THREE_HALVES), .b(p2), .y(corr));
    fisr_fmul u_res (.clk(clk), .en(en), .a(guess_reg[7]), .b(corr), .y(res));

    assign rsqrt_out.valid = vld_reg[FISR_STAGES-1];
    assign rsqrt_out.rsqrt_bits = res;

    `FISR_ASSERT(a_ready_rule, x_in.ready == (!vld_reg[FISR_STAGES-1] || rsqrt_out.ready), "ready rule broken")
    `FISR_ASSERT(a_take, (x_in.valid && x_in.ready) |=> vld_reg[0], "accepted word lost")
    `FISR_ASSERT(a_hold, !en |=> $stable(vld_reg) && $stable(res), "pipe moved during stall")
    `FISR_ASSERT_NEVER(a_drop, !en && !vld_reg[FISR_STAGES-1], "stall with empty output")

endmodule

// ===== bench/fisr_scoreboard.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fisr_scoreboard
// Reciprocal square root predictor and the in-order store of expected
// result words, with the float arithmetic rounded to nearest even.
// ---------------------------------------------------------------------------
package fisr_scoreboard_pkg;

    import fisr_pkg::*;

    function automatic logic [31:0] fp_round(input logic s, input logic [127:0] sig,
                                             input int ex);
        int          k;
        int          sh;
        int          be;
        logic [127:0] keep;
        logic [127:0] rem;
        logic [127:0] half;
        if (sig == 128'b0)
        begin
            return {s, 31'b0};
        end
        k = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (sig[i])
            begin
                k = i;
            end
        end
        sh = k - 23;
        if (sh < -149 - ex)
        begin
            sh = -149 - ex;
        end
        if (sh > 127)
        begin
            keep = 128'b0;
        end
        else if (sh > 0)
        begin
            keep = sig >> sh;
            rem  = sig & ((128'b1 << sh) - 128'b1);
            half = 128'b1 << (sh - 1);
            if (rem > half || (rem == half && keep[0]))
            begin
                keep = keep + 128'b1;
            end
        end
        else
        begin
            keep = sig << (-sh);
        end
        if (keep[24])
        begin
            keep = keep >> 1;
            sh++;
        end
        be = keep[23] ? ex + sh + 150 : 0;
        if (be >= 255)
        begin
            return {s, FISR_EXP_MAX, 23'b0};
        end
        return {s, be[7:0], keep[22:0]};
    endfunction

    function automatic logic [23:0] fp_sig(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    endfunction

    function automatic int fp_ex(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
    endfunction

    function automatic logic is_nan(input logic [31:0] a);
        return a[30:23] == FISR_EXP_MAX && a[22:0] != 23'b0;
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return a[30:23] == FISR_EXP_MAX && a[22:0] == 23'b0;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        logic za;
        logic zb;
        s  = a[31] ^ b[31];
        za = a[30:0] == 31'b0;
        zb = b[30:0] == 31'b0;
        if (is_nan(a))
        begin
            return a | FISR_QBIT;
        end
        if (is_nan(b))
        begin
            return b | FISR_QBIT;
        end
        if ((is_inf(a) && zb) || (is_inf(b) && za))
        begin
            return FISR_QNAN;
        end
        if (is_inf(a) || is_inf(b))
        begin
            return {s, FISR_EXP_MAX, 23'b0};
        end
        return fp_round(s, 128'(fp_sig(a)) * 128'(fp_sig(b)), fp_ex(a) + fp_ex(b));
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]  hi;
        logic [31:0]  lo;
        logic [127:0] ah;
        logic [127:0] al;
        int           d;
        int           ex;
        if (is_nan(a))
        begin
            return a | FISR_QBIT;
        end
        if (is_nan(b))
        begin
            return b | FISR_QBIT;
        end
        if (is_inf(a) && is_inf(b) && a[31] != b[31])
        begin
            return FISR_QNAN;
        end
        if (is_inf(a))
        begin
            return a;
        end
        if (is_inf(b))
        begin
            return b;
        end
        if (fp_ex(b) > fp_ex(a))
        begin
            hi = b;
            lo = a;
        end
        else
        begin
            hi = a;
            lo = b;
        end
        d = fp_ex(hi) - fp_ex(lo);
        if (d <= 60)
        begin
            ah = 128'(fp_sig(hi)) << d;
            al = 128'(fp_sig(lo));
            ex = fp_ex(lo);
        end
        else
        begin
            ah = 128'(fp_sig(hi)) << 62;
            al = (fp_sig(lo) != 24'b0) ? 128'b1 : 128'b0;
            ex = fp_ex(hi) - 62;
        end
        if (hi[31] == lo[31])
        begin
            if (ah == 128'b0 && al == 128'b0)
            begin
                return {hi[31] & lo[31], 31'b0};
            end
            return fp_round(hi[31], ah + al, ex);
        end
        if (ah == al)
        begin
            return 32'b0;
        end
        if (ah > al)
        begin
            return fp_round(hi[31], ah - al, ex);
        end
        return fp_round(lo[31], al - ah, ex);
    endfunction

    function automatic logic [31:0] predict_rsqrt(input logic [31:0] x);
        logic [31:0] half_x;
        logic [31:0] guess;
        logic [31:0] p2;
        logic [31:0] corr;
        half_x = fp_mul(FISR_HALF, x);
        guess  = FISR_MAGIC - (x >> 1);
        p2     = fp_mul(fp_mul(half_x, guess), guess);
        // a NaN subtrahend passes through with its own sign
        corr   = is_nan(p2) ? (p2 | FISR_QBIT) :
                 fp_add(FISR_THREE_HALVES, p2 ^ 32'h80000000);
        return fp_mul(guess, corr);
    endfunction

    class rsqrt_scoreboard;
        logic [31:0] expected_rsqrt[$];
        int          errors;
        int          checked;

        function void note_operand(input logic [31:0] x);
            expected_rsqrt.push_back(predict_rsqrt(x));
        endfunction

        function void check_rsqrt(input logic [31:0] y);
            logic [31:0] want;
            if (expected_rsqrt.size() == 0)
            begin
                $display("%0t: unexpected word, actual %08h", $time, y);
                errors++;
                return;
            end
            want = expected_rsqrt.pop_front();
            checked++;
            if (want !== y)
            begin
                $display("%0t: rsqrt_bits expected %08h actual %08h", $time, want, y);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== bench/fast_inverse_square_root_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fast_inverse_square_root_unit_test
// Streams operand words through the unit under four idle/stall mixes and
// checks every result word against a bit-exact predictor.
// ---------------------------------------------------------------------------
module fast_inverse_square_root_unit_test;

    import fisr_scoreboard_pkg::*;

    localparam int LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   sent = 0;
    logic [31:0] pending[$];

    rsqrt_scoreboard sb = new();

    fisr_x_if     x_if();
    fisr_rsqrt_if r_if();

    fast_inverse_square_root_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .x_in      (x_if.sink),
        .rsqrt_out (r_if.source)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("fast_inverse_square_root_unit: mismatch");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_if.valid  <= 1'b0;
            x_if.x_bits <= 32'b0;
        end
        else
        begin
            if (x_if.valid && x_if.ready)
            begin
                sb.note_operand(x_if.x_bits);
                sent <= sent + 1;
            end
            if (!x_if.valid || x_if.ready)
            begin
                if (pending.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    x_if.x_bits <= pending.pop_front();
                    x_if.valid  <= 1'b1;
                end
                else
                begin
                    x_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_if.ready <= 1'b0;
        end
        else
        begin
            if (r_if.valid && r_if.ready)
            begin
                sb.check_rsqrt(r_if.rsqrt_bits);
            end
            r_if.ready <= $urandom_range(99) >= stall_pct;
        end
    end

    function automatic logic [31:0] random_operand();
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3, 4, 5, 6: return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
            7: return {1'($urandom), 8'h00, 23'($urandom)};
            8: return {1'($urandom), 8'hFF, 23'($urandom_range(0, 3) == 0 ? 0 : $urandom)};
            default: return {1'($urandom), 8'($urandom_range(0, 3) < 2 ?
                             $urandom_range(1, 3) : $urandom_range(252, 254)), 23'($urandom)};
        endcase
    endfunction

    task automatic run_phase(input int idle, input int stall, input int count);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count)
        begin
            pending.push_back(random_operand());
        end
        while (pending.size() > 0 || x_if.valid || sb.expected_rsqrt.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        pending = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                    32'h7FC00000, 32'h7F800001, 32'hFFFFFFFF, 32'h00000001,
                    32'h007FFFFF, 32'h00800000, 32'h3F800000, 32'h40800000,
                    32'h7F7FFFFF, 32'hBF800000, 32'h5F3759DF, 32'hAAAAAAAA,
                    32'h55555555, 32'hFF7FFFFF, 32'h80000001, 32'h3E800000};
        run_phase(0, 0, 0);
        run_phase(0, 0, 225);
        run_phase(58, 0, 225);
        run_phase(0, 58, 225);
        run_phase(23, 23, 225);
        repeat (30) @(posedge clk);
        $display("Sent %0d operands (directed edge patterns, then random), checked %0d results",
                 sent, sb.checked);
        $display("over four mixes of source gaps and sink stalls; %0d errors", sb.errors);
        if (sb.errors == 0 && sb.expected_rsqrt.size() == 0)
        begin
            $display("fast_inverse_square_root_unit: match");
        end
        else
        begin
            $display("fast_inverse_square_root_unit: mismatch");
        end
        $finish;
    end

endmodule
